FILE: design/csd_pkg.sv
// Shared types, constants and pattern tables for the ANSI clear-screen detector.
// No dependencies; every other file refers to it by scoped names.
package csd_pkg;

    localparam int RECORD_DEPTH_DEFAULT = 8;
    localparam int PATTERN_COUNT        = 5;
    localparam int PATTERN_MAX          = 8;
    localparam int PAT_IDX_W            = $clog2(PATTERN_MAX);

    localparam logic [7:0] ESC_BYTE = 8'h1B;

    localparam logic [1:0] CODE_NONE   = 2'd0;
    localparam logic [1:0] CODE_CLEAR  = 2'd1;
    localparam logic [1:0] CODE_ALT    = 2'd2;
    localparam logic [1:0] CODE_NORMAL = 2'd3;

    localparam logic [7:0] PATTERN_BYTES [PATTERN_COUNT][PATTERN_MAX] = '{
        '{8'h1B, "[", "0", "J", 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1B, "[", "J", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1B, "[", "2", "J", 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1B, "[", "?", "1", "0", "4", "9", "h"},
        '{8'h1B, "[", "?", "1", "0", "4", "9", "l"}
    };

    localparam logic [3:0] PATTERN_LEN [PATTERN_COUNT] = '{
        4'd4, 4'd3, 4'd4, 4'd8, 4'd8
    };

    localparam logic [1:0] PATTERN_CODE [PATTERN_COUNT] = '{
        CODE_CLEAR, CODE_CLEAR, CODE_CLEAR, CODE_ALT, CODE_NORMAL
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_chunk;
    } in_word_t;

    typedef struct packed {
        logic [1:0] match_code;
        logic       escape_started;
        logic       in_escape;
        logic [1:0] chunk_clear_code;
    } out_word_t;

endpackage

FILE: design/csd_match.sv
// Pattern compare for one recorded byte: narrows the set of live pattern prefixes.
// Depends on csd_pkg for the pattern tables and match codes.
module csd_match #(
    parameter int CNT_W = 4
) (
    input  logic [7:0]                          data_byte,
    input  logic [CNT_W-1:0]                    slot,
    input  logic [csd_pkg::PATTERN_COUNT-1:0]   alive_in,
    output logic [csd_pkg::PATTERN_COUNT-1:0]   alive_out,
    output logic [1:0]                          match_code
);

    logic             slot_in_table;
    logic [CNT_W-1:0] filled;

    assign slot_in_table = slot < CNT_W'(csd_pkg::PATTERN_MAX);
    assign filled        = slot + CNT_W'(1);

    always_comb
    begin
        alive_out  = '0;
        match_code = csd_pkg::CODE_NONE;
        for (int i = 0; i < csd_pkg::PATTERN_COUNT; i++)
        begin
            alive_out[i] = alive_in[i] && slot_in_table
                && (slot < CNT_W'(csd_pkg::PATTERN_LEN[i]))
                && (csd_pkg::PATTERN_BYTES[i][slot[csd_pkg::PAT_IDX_W-1:0]] == data_byte);
            // later patterns win, as in a forward scan
            if (alive_out[i] && (filled == CNT_W'(csd_pkg::PATTERN_LEN[i])))
            begin
                match_code = csd_pkg::PATTERN_CODE[i];
            end
        end
    end

endmodule

FILE: design/csd_tracker.sv
// Escape-sequence state, recording count, live-pattern set and chunk code.
// Depends on csd_pkg and csd_match; updates once per word when advance is high.
module csd_tracker #(
    parameter int RECORD_DEPTH = csd_pkg::RECORD_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  csd_pkg::in_word_t   word,
    output csd_pkg::out_word_t  result
);

    localparam int CNT_W = $clog2(RECORD_DEPTH + 1);
    localparam int NP    = csd_pkg::PATTERN_COUNT;

    logic             escape_active_reg, escape_active_next;
    logic [1:0]       escape_position_reg, escape_position_next;
    logic [CNT_W-1:0] record_count_reg, record_count_next;
    logic [NP-1:0]    alive_reg, alive_next;
    logic [1:0]       chunk_code_reg, chunk_code_next;

    logic             started;
    logic             active_base;
    logic [1:0]       position_base;
    logic [CNT_W-1:0] count_base;
    logic [NP-1:0]    alive_base;
    logic [NP-1:0]    alive_hit;
    logic [1:0]       hit_code;
    logic [1:0]       match;
    logic [1:0]       chunk_out;

    assign started       = word.data_byte == csd_pkg::ESC_BYTE;
    assign active_base   = started | escape_active_reg;
    assign position_base = started ? 2'd0 : escape_position_reg;
    assign count_base    = started ? '0 : record_count_reg;
    assign alive_base    = started ? '1 : alive_reg;

    csd_match #(
        .CNT_W (CNT_W)
    ) u_match (
        .data_byte  (word.data_byte),
        .slot       (count_base),
        .alive_in   (alive_base),
        .alive_out  (alive_hit),
        .match_code (hit_code)
    );

    always_comb
    begin
        escape_active_next   = active_base;
        escape_position_next = position_base;
        record_count_next    = count_base;
        alive_next           = alive_base;
        match                = csd_pkg::CODE_NONE;
        if (active_base)
        begin
            if (!started)
            begin
                if (position_base < 2'd2)
                begin
                    escape_position_next = position_base + 2'd1;
                end
                if (escape_position_next == 2'd1)
                begin
                    escape_active_next = word.data_byte inside
                        {"[", "(", ")", "#", "6", "5", "0", "3"};
                end
                else
                begin
                    escape_active_next = (word.data_byte inside {["0":"9"]})
                        || (word.data_byte == ";") || (word.data_byte == "?");
                end
            end
            if (count_base < CNT_W'(RECORD_DEPTH))
            begin
                record_count_next = count_base + CNT_W'(1);
                alive_next        = alive_hit;
                match             = hit_code;
                // restart recording after a hit
                if (hit_code != csd_pkg::CODE_NONE)
                begin
                    record_count_next = '0;
                    alive_next        = '1;
                end
            end
        end
        chunk_out       = (match != csd_pkg::CODE_NONE) ? match : chunk_code_reg;
        chunk_code_next = word.end_of_chunk ? csd_pkg::CODE_NONE : chunk_out;
    end

    always_comb
    begin
        result.match_code       = match;
        result.escape_started   = started;
        result.in_escape        = escape_active_next;
        result.chunk_clear_code = chunk_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_active_reg   <= 1'b0;
            escape_position_reg <= 2'd0;
            record_count_reg    <= '0;
            alive_reg           <= '1;
            chunk_code_reg      <= csd_pkg::CODE_NONE;
        end
        else if (advance)
        begin
            escape_active_reg   <= escape_active_next;
            escape_position_reg <= escape_position_next;
            record_count_reg    <= record_count_next;
            alive_reg           <= alive_next;
            chunk_code_reg      <= chunk_code_next;
        end
    end

endmodule

FILE: design/ansi_clear_screen_detector_core.sv
// Top level of the ANSI clear-screen detector: input register, tracker, result register.
// Depends on csd_pkg and csd_tracker.
//
// Usage:
//   Input channel (in_valid / in_ready / in_word) carries one byte of the
//   terminal output stream per word, with end_of_chunk marking the last byte
//   of a write chunk. Output channel (out_valid / out_ready / out_word) returns
//   one result word per input word, in order.
//   Path: a word accepted into the input register passes through the tracker,
//   and its result is captured in the result register, which drives the output.
//   Throughput: one word per cycle while out_ready is high, set by the single
//   pass of pattern compare and escape tracking between the two registers.
//   Reset: all escape, recording and chunk state clears; both registers empty.
//   Stall: when out_ready is low the result holds; the input register still
//   takes one more word, and in_ready drops once both registers are full.
module ansi_clear_screen_detector_core #(
    parameter int RECORD_DEPTH = csd_pkg::RECORD_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  csd_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output csd_pkg::out_word_t  out_word
);

    logic               in_valid_reg, in_valid_next;
    csd_pkg::in_word_t  in_word_reg;
    logic               out_valid_reg, out_valid_next;
    csd_pkg::out_word_t out_word_reg;
    csd_pkg::out_word_t result;
    logic               advance;

    // advance the held word when the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    csd_tracker #(
        .RECORD_DEPTH (RECORD_DEPTH)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .word    (in_word_reg),
        .result  (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_word;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: design/csd_checker.sv
// Port-level checks on the detector's result stream, bound to the top level.
// Depends on csd_pkg and ansi_clear_screen_detector_core.
module csd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input csd_pkg::out_word_t out_word
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result word changed or dropped");

    // an ESC opens a sequence and can never complete a pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.escape_started |->
        out_word.in_escape && (out_word.match_code == csd_pkg::CODE_NONE))
    else $error("ESC word reported a match or no open sequence");

    // a hit becomes the chunk code at once
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.match_code != csd_pkg::CODE_NONE) |->
        out_word.chunk_clear_code == out_word.match_code)
    else $error("chunk code does not follow a match");

    // every pattern ends on a terminating byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.match_code != csd_pkg::CODE_NONE) |-> !out_word.in_escape)
    else $error("sequence still open after a match");

endmodule

bind ansi_clear_screen_detector_core csd_checker u_csd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
